// File: hdl/psu_pkg.sv
// Shared types, constants and predictor helpers for the PNG scanline unfilter.
package psu_pkg;

    localparam int DEF_MAX_ROW_PIXELS  = 4096;
    localparam int DEF_MAX_PIXEL_BYTES = 4;

    // Entries in the queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 13;
    localparam int BPP_W      = 3;
    localparam int ROWS_W     = 16;
    localparam int BPP_SEL_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } filter_t;

    // One classified sample byte on its way to the back end.
    typedef struct packed {
        logic [7:0] data;
        filter_t    kind;
        logic       bad;
        logic       first_px;
        logic       first_row;
        logic       eor;
        logic       eoi;
    } psu_entry_t;

    // Paeth predictor: pick the neighbor closest to a + b - c, ties to a, then b.
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        logic [7:0] pick;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = da + db;
        pa = da[9] ? 10'(-da) : 10'(da);
        pb = db[9] ? 10'(-db) : 10'(db);
        pc = dc[9] ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc)
        begin
            pick = a;
        end
        else if (pb <= pc)
        begin
            pick = b;
        end
        else
        begin
            pick = c;
        end
        return pick;
    endfunction

endpackage

// File: hdl/psu_fifo.sv
// Small register queue that decouples the front end from the back end.
module psu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = psu_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty,
    output logic             full
);
    import psu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign pop_data  = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/psu_front.sv
// Front end: take stream bytes, track row and column, classify sample bytes.
module psu_front #(
    parameter int MAX_ROW_PIXELS  = psu_pkg::DEF_MAX_ROW_PIXELS,
    parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES,
    parameter int LINE_DEPTH      = MAX_ROW_PIXELS * MAX_PIXEL_BYTES,
    parameter int COL_W           = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1,
    parameter int LEN_W           = $clog2(LINE_DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 data_byte,
    input  logic [LEN_W-1:0]           row_len,
    input  logic [psu_pkg::ROWS_W-1:0] eff_rows,
    output logic                       push,
    output psu_pkg::psu_entry_t        entry,
    output logic [COL_W-1:0]           addr
);
    import psu_pkg::*;

    logic              awaiting_reg;
    filter_t           kind_reg;
    logic              bad_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROWS_W-1:0] row_reg;
    logic              eor;
    logic              eoi;

    assign eor  = (32'(col_reg) + 32'd1) >= 32'(row_len);
    assign eoi  = eor && ((32'(row_reg) + 32'd1) >= 32'(eff_rows));
    assign push = accept && !awaiting_reg;
    assign addr = (32'(col_reg) >= 32'(LINE_DEPTH)) ? COL_W'(LINE_DEPTH - 1) : col_reg;

    always_comb
    begin
        entry.data      = data_byte;
        entry.kind      = kind_reg;
        entry.bad       = bad_reg;
        entry.first_px  = (col_reg == '0);
        entry.first_row = (row_reg == '0);
        entry.eor       = eor;
        entry.eoi       = eoi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            kind_reg     <= FLT_NONE;
            bad_reg      <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (accept)
        begin
            if (awaiting_reg)
            begin
                // Filter type byte: unknown types fall back to None.
                if (data_byte > 8'(FLT_PAETH))
                begin
                    kind_reg <= FLT_NONE;
                    bad_reg  <= 1'b1;
                end
                else
                begin
                    kind_reg <= filter_t'(data_byte[2:0]);
                    bad_reg  <= 1'b0;
                end
                col_reg      <= '0;
                awaiting_reg <= 1'b0;
            end
            else if (eor)
            begin
                awaiting_reg <= 1'b1;
                col_reg      <= '0;
                row_reg      <= eoi ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

endmodule

// File: hdl/psu_back.sv
// Back end: line buffer read, predictor, reconstruction and output register.
module psu_back #(
    parameter int MAX_ROW_PIXELS  = psu_pkg::DEF_MAX_ROW_PIXELS,
    parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES,
    parameter int LINE_DEPTH      = MAX_ROW_PIXELS * MAX_PIXEL_BYTES,
    parameter int COL_W           = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  psu_pkg::psu_entry_t           q_entry,
    input  logic [COL_W-1:0]              q_addr,
    output logic                          pop,
    input  logic [psu_pkg::BPP_SEL_W-1:0] bpp_sel,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    pixel_byte,
    output logic                          end_of_row,
    output logic                          end_of_image,
    output logic                          bad_filter
);
    import psu_pkg::*;

    localparam int HIST_W = 8 * MAX_PIXEL_BYTES;

    logic [7:0]        line_mem [LINE_DEPTH];
    logic [7:0]        rdata_reg;
    logic              r_valid_reg;
    psu_entry_t        r_entry_reg;
    logic [COL_W-1:0]  r_addr_reg;
    logic              fwd_reg;
    logic [7:0]        fwd_data_reg;
    logic [HIST_W-1:0] left_reg;
    logic [HIST_W-1:0] upleft_reg;
    logic [HIST_W-1:0] left_next;
    logic [HIST_W-1:0] upleft_next;
    logic              out_valid_reg;
    logic [7:0]        pixel_reg;
    logic              eor_reg;
    logic              eoi_reg;
    logic              bad_reg;

    logic       advance;
    logic       retire;
    logic [4:0] lag;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [8:0] sum_ab;
    logic [7:0] pred;
    logic [7:0] res;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && q_valid;
    assign retire  = advance && r_valid_reg;

    assign lag    = {bpp_sel, 3'b000};
    assign a      = r_entry_reg.first_px ? 8'd0 : 8'(left_reg >> lag);
    assign c      = r_entry_reg.first_px ? 8'd0 : 8'(upleft_reg >> lag);
    assign b      = r_entry_reg.first_row ? 8'd0 : (fwd_reg ? fwd_data_reg : rdata_reg);
    assign sum_ab = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        case (r_entry_reg.kind)
            FLT_NONE:  pred = 8'd0;
            FLT_SUB:   pred = a;
            FLT_UP:    pred = b;
            FLT_AVG:   pred = sum_ab[8:1];
            FLT_PAETH: pred = paeth(a, b, c);
            default:   pred = 8'd0;
        endcase
        res = r_entry_reg.data + pred;
        left_next   = (r_entry_reg.first_px ? '0 : (left_reg << 8)) | HIST_W'(res);
        upleft_next = (r_entry_reg.first_px ? '0 : (upleft_reg << 8)) | HIST_W'(b);
    end

    // Line buffer: read as an entry leaves the queue, write as it retires.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rdata_reg <= line_mem[q_addr];
        end
        if (retire)
        begin
            line_mem[r_addr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            r_valid_reg   <= q_valid;
            out_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            r_entry_reg  <= q_entry;
            r_addr_reg   <= q_addr;
            // Read and write of the same address on one edge: take the new byte.
            fwd_reg      <= r_valid_reg && (r_addr_reg == q_addr);
            fwd_data_reg <= res;
        end
        if (retire)
        begin
            left_reg   <= left_next;
            upleft_reg <= upleft_next;
            pixel_reg  <= res;
            eor_reg    <= r_entry_reg.eor;
            eoi_reg    <= r_entry_reg.eoi;
            bad_reg    <= r_entry_reg.bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_byte   = pixel_reg;
    assign end_of_row   = eor_reg;
    assign end_of_image = eoi_reg;
    assign bad_filter   = bad_reg;

endmodule

// File: hdl/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter: configuration, front end, queue, back end.
//
// Takes an inflated PNG scanline stream (8-bit samples) one byte per transaction
// and returns one reconstructed sample byte per sample byte; the filter type byte
// at the head of each row gives no output. Throughput is one input byte per clock
// cycle while neither in_stall nor out_stall holds the flow; an accepted sample
// byte passes through the queue, the line buffer read register and the output
// register. The rate is set by the back end's loop from a reconstructed byte
// to the left-pixel history used by the next byte. The line buffer holds
// MAX_ROW_PIXELS * MAX_PIXEL_BYTES bytes and needs no clearing after reset: the
// first row never uses what it reads from it. Width, pixel size and row count
// must be written only while no transaction is in flight; zero values count as
// one and values above the parameter limits are clamped. A filter type above
// Paeth is decoded as None and raises bad_filter on every byte of that row.
module png_scanline_unfilter #(
    parameter int MAX_ROW_PIXELS  = psu_pkg::DEF_MAX_ROW_PIXELS,
    parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     data_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     pixel_byte,
    output logic                           end_of_row,
    output logic                           end_of_image,
    output logic                           bad_filter
);
    import psu_pkg::*;

    localparam int LINE_DEPTH = MAX_ROW_PIXELS * MAX_PIXEL_BYTES;
    localparam int COL_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
    localparam int PIX_W      = $clog2(MAX_ROW_PIXELS + 1);
    localparam int PROD_W     = PIX_W + BPP_W;
    localparam int ENTRY_W    = $bits(psu_entry_t);
    localparam int Q_W        = ENTRY_W + COL_W;

    logic [WIDTH_W-1:0] width_reg;
    logic [BPP_W-1:0]   bpp_reg;
    logic [ROWS_W-1:0]  rows_reg;

    logic [PIX_W-1:0]  eff_width;
    logic [BPP_W-1:0]  eff_bpp;
    logic [ROWS_W-1:0] eff_rows;
    logic [PROD_W-1:0] row_prod;
    logic [LEN_W-1:0]  row_len;
    logic [BPP_SEL_W-1:0] bpp_sel;

    logic             accept;
    logic             push;
    psu_entry_t       push_entry;
    logic [COL_W-1:0] push_addr;
    logic             q_full;
    logic             q_valid;
    logic             pop;
    logic [Q_W-1:0]   q_data;
    psu_entry_t       q_entry;
    logic [COL_W-1:0] q_addr;

    // Configuration registers; writes to an index past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_W'(1);
            bpp_reg   <= BPP_W'(4);
            rows_reg  <= ROWS_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_WIDTH:   width_reg <= cfg_data[WIDTH_W-1:0];
                REG_PIXEL_BYTES: bpp_reg   <= cfg_data[BPP_W-1:0];
                REG_IMAGE_ROWS:  rows_reg  <= cfg_data[ROWS_W-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp the settings to their legal range; row length in bytes follows.
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = PIX_W'(1);
        end
        else if (32'(width_reg) > 32'(MAX_ROW_PIXELS))
        begin
            eff_width = PIX_W'(MAX_ROW_PIXELS);
        end
        else
        begin
            eff_width = PIX_W'(width_reg);
        end

        if (bpp_reg == '0)
        begin
            eff_bpp = BPP_W'(1);
        end
        else if (32'(bpp_reg) > 32'(MAX_PIXEL_BYTES))
        begin
            eff_bpp = BPP_W'(MAX_PIXEL_BYTES);
        end
        else
        begin
            eff_bpp = bpp_reg;
        end

        eff_rows = (rows_reg == '0) ? ROWS_W'(1) : rows_reg;
        row_prod = PROD_W'(eff_width) * PROD_W'(eff_bpp);
        row_len  = LEN_W'(row_prod);
        bpp_sel  = BPP_SEL_W'(eff_bpp - BPP_W'(1));
    end

    // Hold off the sender only when the queue is full.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    psu_front #(
        .MAX_ROW_PIXELS  (MAX_ROW_PIXELS),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .row_len   (row_len),
        .eff_rows  (eff_rows),
        .push      (push),
        .entry     (push_entry),
        .addr      (push_addr)
    );

    psu_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_entry, push_addr}),
        .pop       (pop),
        .pop_data  (q_data),
        .not_empty (q_valid),
        .full      (q_full)
    );

    assign q_entry = psu_entry_t'(q_data[Q_W-1:COL_W]);
    assign q_addr  = q_data[COL_W-1:0];

    psu_back #(
        .MAX_ROW_PIXELS  (MAX_ROW_PIXELS),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_addr       (q_addr),
        .pop          (pop),
        .bpp_sel      (bpp_sel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_byte   (pixel_byte),
        .end_of_row   (end_of_row),
        .end_of_image (end_of_image),
        .bad_filter   (bad_filter)
    );

endmodule
